@@ rtl/sfdl_pkg.sv @@
`default_nettype none

package sfdl_pkg;

    // Fixed sample format of the ports and of the line memories.
    localparam int SAMPLE_BITS = 24;
    // Filter output and filter state widths.
    localparam int YW = SAMPLE_BITS + 2;
    localparam int FW = SAMPLE_BITS + 10;

    localparam int LINE_DEPTH_DEF = 131072;
    localparam int SINE_TABLE_DEF = 1024;

    // Quarter-wave sine polynomial coefficients.
    localparam logic [15:0] SIN_A = 16'd51472;
    localparam logic [14:0] SIN_B = 15'd21165;
    localparam logic [11:0] SIN_C = 12'd2461;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY      = 3'd0,
        CFG_FEEDBACK   = 3'd1,
        CFG_WET        = 3'd2,
        CFG_PING_PONG  = 3'd3,
        CFG_FILT_MODE  = 3'd4,
        CFG_FILT_ALPHA = 3'd5,
        CFG_MOD_DEPTH  = 3'd6,
        CFG_PHASE_STEP = 3'd7
    } t_cfg_idx;

    localparam logic [1:0] FILT_NONE = 2'd0;
    localparam logic [1:0] FILT_LP   = 2'd1;
    localparam logic [1:0] FILT_HP   = 2'd2;

    typedef struct packed {
        logic [16:0] delay_samples;
        logic [14:0] feedback_gain;
        logic [15:0] wet_mix;
        logic        ping_pong;
        logic [1:0]  filter_mode;
        logic [15:0] filter_alpha;
        logic [15:0] mod_depth;
        logic [30:0] lfo_phase_step;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        delay_samples:  17'd12000,
        feedback_gain:  15'd16384,
        wet_mix:        16'd16384,
        ping_pong:      1'b0,
        filter_mode:    FILT_NONE,
        filter_alpha:   16'd32768,
        mod_depth:      16'd0,
        lfo_phase_step: 31'd0
    };

    // One strobe per processing step of a channel.
    typedef struct packed {
        logic load_a;
        logic tap;
        logic diff;
        logic fmul;
        logic fupd;
        logic fb;
        logic wr;
        logic dry;
        logic mix;
    } t_chan_ctl;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (x > hi) begin
            return hi[SAMPLE_BITS-1:0];
        end else if (x < lo) begin
            return lo[SAMPLE_BITS-1:0];
        end
        return x[SAMPLE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/sfdl_in_if.sv @@
`default_nettype none

interface sfdl_in_if import sfdl_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;

    modport source (output valid, output sample_left, output sample_right, input ready);
    modport sink   (input valid, input sample_left, input sample_right, output ready);
endinterface

`default_nettype wire

@@ rtl/sfdl_out_if.sv @@
`default_nettype none

interface sfdl_out_if import sfdl_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;

    modport source (output valid, output out_left, output out_right, input ready);
    modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

`default_nettype wire

@@ rtl/sfdl_lfo.sv @@
`default_nettype none

// LFO phase, sine evaluation and swept delay, at most two multiplies per stage.
module sfdl_lfo import sfdl_pkg::*; #(
    parameter int LINE_DEPTH      = LINE_DEPTH_DEF,
    parameter int SINE_TABLE_SIZE = SINE_TABLE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [16:0]                   i_delay_samples,
    input  logic [15:0]                   i_mod_depth,
    input  logic [30:0]                   i_phase_step,
    output logic                          o_done,
    output logic [$clog2(LINE_DEPTH)-1:0] o_whole,
    output logic [7:0]                    o_frac
);

    localparam int AW  = $clog2(LINE_DEPTH);
    localparam int TW  = $clog2(SINE_TABLE_SIZE);
    localparam int CW  = ((AW > 17) ? AW : 17) + 1;
    localparam int PW  = 31 + AW;
    localparam int XW  = PW - 22;
    localparam int DQW = AW + 10;
    localparam logic signed [DQW-1:0] DQ_MIN = DQW'(256);
    localparam logic signed [DQW-1:0] DQ_MAX = DQW'((LINE_DEPTH - 1) * 256);

    logic [31:0]     r_phase;
    logic [9:0]      r_v;
    logic [AW-1:0]   r_d;
    logic [14:0]     r_r;
    logic [1:0]      r_quad;
    logic [14:0]     r_t2;
    logic [14:0]     r_t4;
    logic [14:0]     r_bt;
    logic [15:0]     r_poly;
    logic [14:0]     r_mag;
    logic            r_sign;
    logic [30:0]     r_m;
    logic [PW-1:0]   r_pm;
    logic [XW-1:0]   r_q;
    logic [AW-1:0]   r_whole;
    logic [7:0]      r_frac;

    logic [CW-1:0]   ds;
    logic [AW-1:0]   n_d;
    logic [15:0]     u;
    logic [14:0]     n_r;
    logic [29:0]     sq2;
    logic [29:0]     sq4;
    logic [29:0]     pb;
    logic [26:0]     pc;
    logic [16:0]     poly_w;
    logic [30:0]     ps;
    logic [14:0]     n_mag;
    logic [XW+31:0]  qprod;
    logic signed [DQW-1:0] base;
    logic signed [DQW-1:0] off;
    logic signed [DQW-1:0] dq;
    logic signed [DQW-1:0] dq_c;

    always_comb begin
        ds = CW'(i_delay_samples);
        if (ds == '0) begin
            n_d = AW'(1);
        end else if (ds > CW'(LINE_DEPTH - 1)) begin
            n_d = AW'(LINE_DEPTH - 1);
        end else begin
            n_d = ds[AW-1:0];
        end
    end

    assign u      = 16'(r_phase[31 -: TW]) << (16 - TW);
    assign n_r    = u[14] ? (15'd16384 - {1'b0, u[13:0]}) : {1'b0, u[13:0]};
    assign sq2    = 30'(r_r) * 30'(r_r);
    assign sq4    = 30'(r_t2) * 30'(r_t2);
    assign pb     = 30'(SIN_B) * 30'(r_t2);
    assign pc     = 27'(SIN_C) * 27'(r_t4);
    assign poly_w = 17'(SIN_A) - 17'(r_bt) + 17'(pc[26:14]);
    assign ps     = 31'(r_poly) * 31'(r_r);
    assign n_mag  = (ps[30:14] > 17'd32767) ? 15'h7FFF : ps[28:14];
    // Division by ten by reciprocal multiply, exact for values below 2^32.
    assign qprod  = (XW+32)'(r_pm[PW-1:22]) * (XW+32)'(32'hCCCC_CCCD);

    always_comb begin
        base = $signed(DQW'({r_d, 8'h00}));
        off  = $signed(DQW'(r_q));
        dq   = r_sign ? (base - off) : (base + off);
        if (dq < DQ_MIN) begin
            dq_c = DQ_MIN;
        end else if (dq > DQ_MAX) begin
            dq_c = DQ_MAX;
        end else begin
            dq_c = dq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_v     <= '0;
        end else begin
            r_v <= {r_v[8:0], i_start};
            if (i_start && (i_mod_depth != '0)) begin
                r_phase <= r_phase + {1'b0, i_phase_step};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d <= n_d;
        end
        if (r_v[0]) begin
            r_r    <= n_r;
            r_quad <= u[15:14];
        end
        if (r_v[1]) begin
            r_t2 <= sq2[28:14];
        end
        if (r_v[2]) begin
            r_t4 <= sq4[28:14];
            r_bt <= pb[28:14];
        end
        if (r_v[3]) begin
            r_poly <= poly_w[15:0];
        end
        if (r_v[4]) begin
            r_mag  <= n_mag;
            r_sign <= r_quad[1];
        end
        if (r_v[5]) begin
            r_m <= 31'(i_mod_depth) * 31'(r_mag);
        end
        if (r_v[6]) begin
            r_pm <= PW'(r_m) * PW'(r_d);
        end
        if (r_v[7]) begin
            r_q <= XW'(qprod[XW+31:35]);
        end
        if (r_v[8]) begin
            r_whole <= dq_c[AW+7:8];
            r_frac  <= dq_c[7:0];
        end
    end

    assign o_done  = r_v[9];
    assign o_whole = r_whole;
    assign o_frac  = r_frac;

endmodule

`default_nettype wire

@@ rtl/sfdl_chan.sv @@
`default_nettype none

// One channel: interpolated tap, one-pole filter, feedback sample and mix.
module sfdl_chan import sfdl_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_chan_ctl                     i_ctl,
    input  t_cfg                          i_cfg,
    input  logic signed [SAMPLE_BITS-1:0] i_q,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic [7:0]                    i_frac,
    input  logic signed [YW-1:0]          i_y_other,
    output logic signed [YW-1:0]          o_y,
    output logic signed [SAMPLE_BITS-1:0] o_wr,
    output logic signed [SAMPLE_BITS-1:0] o_out
);

    logic signed [FW-1:0]          r_s;
    logic signed [SAMPLE_BITS-1:0] r_a;
    logic signed [SAMPLE_BITS-1:0] r_tap;
    logic signed [FW-1:0]          r_diff;
    logic signed [FW+16:0]         r_fp;
    logic signed [YW-1:0]          r_y;
    logic signed [YW+15:0]         r_fbp;
    logic signed [SAMPLE_BITS-1:0] r_wr;
    logic signed [YW+16:0]         r_wp;
    logic signed [SAMPLE_BITS+17:0] r_dp;
    logic signed [SAMPLE_BITS-1:0] r_o;

    logic signed [SAMPLE_BITS:0]   d_ba;
    logic signed [SAMPLE_BITS+9:0] tap_prod;
    logic signed [SAMPLE_BITS+9:0] tap_sum;
    logic signed [FW-1:0]          n_diff;
    logic signed [FW-1:0]          n_s;
    logic signed [FW-1:0]          fp_sh;
    logic signed [FW-1:0]          s_sh;
    logic signed [FW-1:0]          d_sh;
    logic signed [YW-1:0]          n_y;
    logic signed [YW-1:0]          fb_y;
    logic signed [63:0]            wr_sum;
    logic signed [63:0]            mix_sum;
    logic signed [17:0]            dry;
    logic                          filt_on;

    assign filt_on  = (i_cfg.filter_mode == FILT_LP) || (i_cfg.filter_mode == FILT_HP);
    assign d_ba     = (SAMPLE_BITS+1)'(i_q) - (SAMPLE_BITS+1)'(r_a);
    assign tap_prod = (SAMPLE_BITS+10)'(d_ba) * (SAMPLE_BITS+10)'($signed({1'b0, i_frac}));
    assign tap_sum  = (SAMPLE_BITS+10)'(r_a) + (tap_prod >>> 8);
    assign n_diff   = FW'($signed({r_tap, 8'h00})) - r_s;
    assign fp_sh    = FW'(r_fp >>> 16);
    assign n_s      = r_s + fp_sh;
    assign s_sh     = n_s >>> 8;
    assign d_sh     = r_diff >>> 8;
    assign fb_y     = i_cfg.ping_pong ? i_y_other : r_y;
    assign wr_sum   = 64'(i_x) + 64'(r_fbp >>> 15);
    assign dry      = 18'sd32768 - $signed({2'b00, i_cfg.wet_mix});
    assign mix_sum  = (64'(r_wp) + 64'(r_dp)) >>> 15;

    always_comb begin
        case (i_cfg.filter_mode)
            FILT_LP: n_y = YW'(s_sh);
            FILT_HP: n_y = YW'(d_sh);
            default: n_y = YW'(r_tap);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s <= '0;
        end else if (i_ctl.fupd && filt_on) begin
            r_s <= n_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_a) begin
            r_a <= i_q;
        end
        if (i_ctl.tap) begin
            r_tap <= tap_sum[SAMPLE_BITS-1:0];
        end
        if (i_ctl.diff) begin
            r_diff <= n_diff;
        end
        if (i_ctl.fmul) begin
            r_fp <= (FW+17)'(r_diff) * (FW+17)'($signed({1'b0, i_cfg.filter_alpha}));
        end
        if (i_ctl.fupd) begin
            r_y <= n_y;
        end
        if (i_ctl.fb) begin
            r_fbp <= (YW+16)'(fb_y) * (YW+16)'($signed({1'b0, i_cfg.feedback_gain}));
        end
        if (i_ctl.wr) begin
            r_wr <= sat_sample(wr_sum);
            r_wp <= (YW+17)'(r_y) * (YW+17)'($signed({1'b0, i_cfg.wet_mix}));
        end
        if (i_ctl.dry) begin
            r_dp <= (SAMPLE_BITS+18)'(i_x) * (SAMPLE_BITS+18)'(dry);
        end
        if (i_ctl.mix) begin
            r_o <= sat_sample(mix_sum);
        end
    end

    assign o_y   = r_y;
    assign o_wr  = r_wr;
    assign o_out = r_o;

endmodule

`default_nettype wire

@@ rtl/stereo_feedback_delay_line.sv @@
// Channel   Dir  Handshake          Payload
// i_in      in   valid / ready      sample_left, sample_right (signed)
// o_out     out  valid / ready      out_left, out_right (signed, saturated)
// i_cfg_*   in   i_cfg_wr_en only   i_cfg_index, i_cfg_data
//
// One beat at a time: the accepting edge starts the LFO and delay pipeline,
// then the read, compute and write-back sequence on the line memories runs
// up to the edge that loads the output register; the next beat can be
// accepted in the cycle after that, so a new beat waits for the last one.
// After reset a clearing pass writes zero to all LINE_DEPTH entries of both
// lines while i_in.ready stays low; config writes are taken.
// A result waiting in the output register stalls only the final step; the
// next input beat is accepted while it waits.
`default_nettype none

module stereo_feedback_delay_line import sfdl_pkg::*; #(
    parameter int LINE_DEPTH      = LINE_DEPTH_DEF,
    parameter int SINE_TABLE_SIZE = SINE_TABLE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sfdl_in_if.sink               i_in,
    sfdl_out_if.source            o_out,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(LINE_DEPTH - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LFO, S_ADDR, S_RD0, S_RD1, S_TAP, S_DIFF,
        S_FMUL, S_FUPD, S_FB, S_WR, S_DRY, S_MIX, S_OUT
    } t_state;

    t_state  r_state;
    t_cfg    r_cfg;
    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] r_w;
    logic [AW-1:0] r_p0;
    logic [AW-1:0] r_p1;
    logic          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_left;
    logic signed [SAMPLE_BITS-1:0] r_out_right;
    logic signed [SAMPLE_BITS-1:0] r_x_l;
    logic signed [SAMPLE_BITS-1:0] r_x_r;

    // The delay lines. Reads are registered.
    logic signed [SAMPLE_BITS-1:0] r_line_left  [LINE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_line_right [LINE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_q_l;
    logic signed [SAMPLE_BITS-1:0] r_q_r;

    logic          in_acc;
    logic          lfo_done;
    logic [AW-1:0] lfo_whole;
    logic [7:0]    lfo_frac;
    logic [AW-1:0] n_p0;
    logic [AW-1:0] n_p1;
    logic [AW-1:0] w_next;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic signed [SAMPLE_BITS-1:0] wd_l;
    logic signed [SAMPLE_BITS-1:0] wd_r;
    t_chan_ctl     ctl;
    logic signed [YW-1:0]          y_l;
    logic signed [YW-1:0]          y_r;
    logic signed [SAMPLE_BITS-1:0] wr_l;
    logic signed [SAMPLE_BITS-1:0] wr_r;
    logic signed [SAMPLE_BITS-1:0] mix_l;
    logic signed [SAMPLE_BITS-1:0] mix_r;

    assign i_in.ready      = (r_state == S_IDLE);
    assign in_acc          = i_in.valid && (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.out_left  = r_out_left;
    assign o_out.out_right = r_out_right;

    // Configuration registers; unknown indexes never occur with a 3-bit index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DELAY:      r_cfg.delay_samples  <= i_cfg_data[16:0];
                CFG_FEEDBACK:   r_cfg.feedback_gain  <= i_cfg_data[14:0];
                CFG_WET:        r_cfg.wet_mix        <= i_cfg_data[15:0];
                CFG_PING_PONG:  r_cfg.ping_pong      <= i_cfg_data[0];
                CFG_FILT_MODE:  r_cfg.filter_mode    <= i_cfg_data[1:0];
                CFG_FILT_ALPHA: r_cfg.filter_alpha   <= i_cfg_data[15:0];
                CFG_MOD_DEPTH:  r_cfg.mod_depth      <= i_cfg_data[15:0];
                CFG_PHASE_STEP: r_cfg.lfo_phase_step <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    sfdl_lfo #(
        .LINE_DEPTH      (LINE_DEPTH),
        .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
    ) u_lfo (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (in_acc),
        .i_delay_samples (r_cfg.delay_samples),
        .i_mod_depth     (r_cfg.mod_depth),
        .i_phase_step    (r_cfg.lfo_phase_step),
        .o_done          (lfo_done),
        .o_whole         (lfo_whole),
        .o_frac          (lfo_frac)
    );

    // Tap addresses: whole delay n is in [1, LINE_DEPTH-1], so p0 never hits w.
    always_comb begin
        if (r_w >= lfo_whole) begin
            n_p0 = r_w - lfo_whole;
        end else begin
            n_p0 = AW'((AW+1)'(r_w) + (AW+1)'(LINE_DEPTH) - (AW+1)'(lfo_whole));
        end
        n_p1 = (n_p0 == '0) ? LAST : (n_p0 - AW'(1));
    end

    assign w_next = (r_w == LAST) ? '0 : (r_w + AW'(1));

    // Step strobes for both channels.
    always_comb begin
        ctl = '0;
        unique case (r_state)
            S_RD1:   ctl.load_a = 1'b1;
            S_TAP:   ctl.tap    = 1'b1;
            S_DIFF:  ctl.diff   = 1'b1;
            S_FMUL:  ctl.fmul   = 1'b1;
            S_FUPD:  ctl.fupd   = 1'b1;
            S_FB:    ctl.fb     = 1'b1;
            S_WR:    ctl.wr     = 1'b1;
            S_DRY:   ctl.dry    = 1'b1;
            S_MIX:   ctl.mix    = 1'b1;
            default: ;
        endcase
    end

    // Memory access: clearing pass, two tap reads, one write-back per beat.
    assign mem_we    = (r_state == S_CLEAR) || (r_state == S_DRY);
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_w;
    assign wd_l      = (r_state == S_CLEAR) ? '0 : wr_l;
    assign wd_r      = (r_state == S_CLEAR) ? '0 : wr_r;
    assign mem_re    = (r_state == S_RD0) || (r_state == S_RD1);
    assign mem_raddr = (r_state == S_RD0) ? r_p0 : r_p1;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_line_left[mem_waddr] <= wd_l;
        end
        if (mem_re) begin
            r_q_l <= r_line_left[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_line_right[mem_waddr] <= wd_r;
        end
        if (mem_re) begin
            r_q_r <= r_line_right[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x_l <= i_in.sample_left;
            r_x_r <= i_in.sample_right;
        end
    end

    sfdl_chan u_chan_l (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_cfg     (r_cfg),
        .i_q       (r_q_l),
        .i_x       (r_x_l),
        .i_frac    (lfo_frac),
        .i_y_other (y_r),
        .o_y       (y_l),
        .o_wr      (wr_l),
        .o_out     (mix_l)
    );

    sfdl_chan u_chan_r (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_cfg     (r_cfg),
        .i_q       (r_q_r),
        .i_x       (r_x_r),
        .i_frac    (lfo_frac),
        .i_y_other (y_l),
        .o_y       (y_r),
        .o_wr      (wr_r),
        .o_out     (mix_r)
    );

    // Sequencer and output register. The output step either loads a new
    // beat or holds the waiting one, so the plain clear applies elsewhere.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_w         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= (r_clr_addr == LAST) ? '0 : (r_clr_addr + AW'(1));
                    if (r_clr_addr == LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_state <= S_LFO;
                    end
                end
                S_LFO: begin
                    if (lfo_done) begin
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    r_p0    <= n_p0;
                    r_p1    <= n_p1;
                    r_state <= S_RD0;
                end
                S_RD0:  r_state <= S_RD1;
                S_RD1:  r_state <= S_TAP;
                S_TAP:  r_state <= S_DIFF;
                S_DIFF: r_state <= S_FMUL;
                S_FMUL: r_state <= S_FUPD;
                S_FUPD: r_state <= S_FB;
                S_FB:   r_state <= S_WR;
                S_WR:   r_state <= S_DRY;
                S_DRY:  r_state <= S_MIX;
                S_MIX:  r_state <= S_OUT;
                S_OUT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_left  <= mix_l;
                        r_out_right <= mix_r;
                        r_w         <= w_next;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/sfdl_checker.sv @@
`default_nettype none

module sfdl_checker import sfdl_pkg::*; (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic signed [SAMPLE_BITS-1:0] i_out_left,
    input logic signed [SAMPLE_BITS-1:0] i_out_right
);

    // The clearing pass keeps the input closed right after reset.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready right after reset");

    // Only one beat is in flight: the input closes after each acceptance.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input stayed open after an accepted beat");

    // A result never appears in the cycle after its input was taken.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !$rose(i_out_valid))
        else $error("result appeared too early");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_left) && $stable(i_out_right)))
        else $error("stalled output beat changed");

endmodule

bind stereo_feedback_delay_line sfdl_checker u_sfdl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_left  (o_out.out_left),
    .i_out_right (o_out.out_right)
);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
`default_nettype none

module testbench;
    import sfdl_pkg::*;

    localparam int DEPTH     = LINE_DEPTH_DEF;
    localparam int LIMIT     = 1500000;
    localparam int PHASES    = 12;
    localparam int PER_PHASE = 90;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
    } t_pair;

    // One row of the directed table. When has_fixed is set, the expected
    // output is the typed-in pair instead of the predicted one.
    typedef struct {
        logic signed [SAMPLE_BITS-1:0] in_l;
        logic signed [SAMPLE_BITS-1:0] in_r;
        bit                            has_fixed;
        logic signed [SAMPLE_BITS-1:0] exp_l;
        logic signed [SAMPLE_BITS-1:0] exp_r;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    sfdl_in_if  in_if ();
    sfdl_out_if out_if ();

    stereo_feedback_delay_line uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if.sink),
        .o_out       (out_if.source),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Mirror of the block: both echo lines, the write pointer, the two
    // filter states, the LFO phase and the register file.
    int          echo_l [DEPTH];
    int          echo_r [DEPTH];
    int unsigned wr_ptr;
    longint      tone_l;
    longint      tone_r;
    bit [31:0]   lfo_acc;
    t_cfg        regs;

    t_pair expected_beats[$];
    int    fails;
    int    beats_in;
    int    beats_out;
    int    cycles;
    bit    idling_on;
    bit    long_hold_req;

    initial begin
        in_if.valid        = 1'b0;
        in_if.sample_left  = '0;
        in_if.sample_right = '0;
        out_if.ready       = 1'b0;
        regs     = CFG_RESET;
        wr_ptr   = 0;
        tone_l   = 0;
        tone_r   = 0;
        lfo_acc  = '0;
        fails    = 0;
        beats_in = 0;
        beats_out = 0;
        cycles   = 0;
        idling_on = 1'b1;
        long_hold_req = 1'b0;
        foreach (echo_l[k]) begin
            echo_l[k] = 0;
            echo_r[k] = 0;
        end
    end

    function automatic longint clamp_sample(longint x);
        if (x > 64'sd8388607) begin
            return 64'sd8388607;
        end
        if (x < -64'sd8388608) begin
            return -64'sd8388608;
        end
        return x;
    endfunction

    // Q15 sine from the top bits of the phase, evaluated by the odd
    // polynomial over a quarter turn and mirrored into the other quarters.
    function automatic longint lfo_sine(bit [31:0] ph);
        longint idx, u, quad, r, t2, poly, s;
        idx  = longint'(ph >> 22);
        u    = idx * 64;
        quad = (u >> 14) & 3;
        r    = u & 16383;
        if (quad[0]) begin
            r = 16384 - r;
        end
        t2   = (r * r) >> 14;
        poly = longint'(SIN_A) - ((longint'(SIN_B) * t2) >> 14)
             + ((longint'(SIN_C) * ((t2 * t2) >> 14)) >> 14);
        s    = (poly * r) >> 14;
        if (s > 32767) begin
            s = 32767;
        end
        if (quad[1]) begin
            s = -s;
        end
        return s;
    endfunction

    // Interpolated read between the entries n and n+1 behind the pointer.
    function automatic longint line_tap(bit right, int unsigned n, int unsigned f);
        int unsigned p0, p1;
        longint a, b;
        p0 = (wr_ptr >= n) ? wr_ptr - n : wr_ptr + DEPTH - n;
        if (p0 >= DEPTH) begin
            p0 = 0;
        end
        p1 = (p0 == 0) ? DEPTH - 1 : p0 - 1;
        a = right ? echo_r[p0] : echo_l[p0];
        b = right ? echo_r[p1] : echo_l[p1];
        return (a * (256 - longint'(f)) + b * longint'(f)) >>> 8;
    endfunction

    // One-pole tone filter; modes other than low-pass and high-pass pass through.
    task automatic tone_filter(input longint x, inout longint st, output longint y);
        longint diff;
        if (regs.filter_mode != FILT_LP && regs.filter_mode != FILT_HP) begin
            y = x;
        end else begin
            diff = x * 256 - st;
            y = diff >>> 8;
            st += (longint'(regs.filter_alpha) * diff) >>> 16;
            if (regs.filter_mode == FILT_LP) begin
                y = st >>> 8;
            end
        end
    endtask

    task automatic predict_echo(input longint xl, input longint xr, output t_pair res);
        longint d, dq, tl, tr, yl, yr, fbl, fbr, dry;
        d = longint'(regs.delay_samples);
        if (d < 1) begin
            d = 1;
        end
        if (d > DEPTH - 1) begin
            d = DEPTH - 1;
        end
        dq = d * 256;
        if (regs.mod_depth != 0) begin
            lfo_acc = lfo_acc + {1'b0, regs.lfo_phase_step};
            dq += (longint'(regs.mod_depth) * lfo_sine(lfo_acc) * d) / (10 * 4194304);
        end
        if (dq < 256) begin
            dq = 256;
        end
        if (dq > longint'(DEPTH - 1) * 256) begin
            dq = longint'(DEPTH - 1) * 256;
        end
        tl = line_tap(1'b0, int'(dq >> 8), int'(dq & 255));
        tr = line_tap(1'b1, int'(dq >> 8), int'(dq & 255));
        tone_filter(tl, tone_l, yl);
        tone_filter(tr, tone_r, yr);
        // Ping-pong sends each channel's tap into the opposite line.
        fbl = regs.ping_pong ? yr : yl;
        fbr = regs.ping_pong ? yl : yr;
        echo_l[wr_ptr] = int'(clamp_sample(xl + ((fbl * longint'(regs.feedback_gain)) >>> 15)));
        echo_r[wr_ptr] = int'(clamp_sample(xr + ((fbr * longint'(regs.feedback_gain)) >>> 15)));
        dry = 32768 - longint'(regs.wet_mix);
        res.left  = clamp_sample((xl * dry + yl * longint'(regs.wet_mix)) >>> 15);
        res.right = clamp_sample((xr * dry + yr * longint'(regs.wet_mix)) >>> 15);
        wr_ptr = (wr_ptr + 1 >= DEPTH) ? 0 : wr_ptr + 1;
    endtask

    // Register write on the plain config port; the mirror follows at once.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_DELAY:      regs.delay_samples  = data[16:0];
            CFG_FEEDBACK:   regs.feedback_gain  = data[14:0];
            CFG_WET:        regs.wet_mix        = data[15:0];
            CFG_PING_PONG:  regs.ping_pong      = data[0];
            CFG_FILT_MODE:  regs.filter_mode    = data[1:0];
            CFG_FILT_ALPHA: regs.filter_alpha   = data[15:0];
            CFG_MOD_DEPTH:  regs.mod_depth      = data[15:0];
            CFG_PHASE_STEP: regs.lfo_phase_step = data[30:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input t_cfg c);
        write_reg(CFG_DELAY,      31'(c.delay_samples));
        write_reg(CFG_FEEDBACK,   31'(c.feedback_gain));
        write_reg(CFG_WET,        31'(c.wet_mix));
        write_reg(CFG_PING_PONG,  31'(c.ping_pong));
        write_reg(CFG_FILT_MODE,  31'(c.filter_mode));
        write_reg(CFG_FILT_ALPHA, 31'(c.filter_alpha));
        write_reg(CFG_MOD_DEPTH,  31'(c.mod_depth));
        write_reg(CFG_PHASE_STEP, c.lfo_phase_step);
    endtask

    // Offers one beat, optionally after an idle burst, and holds it until
    // the block takes it. The expectation is queued at the accepting edge.
    task automatic send_beat(input t_row row);
        t_pair res;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.sample_left  <= row.in_l;
        in_if.sample_right <= row.in_r;
        do begin
            @(posedge i_clk);
        end while (!in_if.ready);
        predict_echo(longint'(row.in_l), longint'(row.in_r), res);
        if (row.has_fixed) begin
            res.left  = row.exp_l;
            res.right = row.exp_r;
        end
        expected_beats.push_back(res);
        beats_in++;
    endtask

    // Lets the pipeline run dry so the block is idle before any register write.
    task automatic drain();
        in_if.valid <= 1'b0;
        while (expected_beats.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'($signed($urandom_range(0, 511)) - 256);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic t_cfg pick_setting();
        t_cfg c;
        c.delay_samples  = ($urandom_range(0, 9) < 7) ? 17'($urandom_range(1, 64))
                                                     : 17'($urandom);
        c.feedback_gain  = ($urandom_range(0, 3) == 0) ? 15'($urandom)
                                                     : 15'($urandom_range(0, 31129));
        c.wet_mix        = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 32768));
        c.ping_pong      = 1'($urandom);
        c.filter_mode    = 2'($urandom);
        c.filter_alpha   = 16'($urandom);
        c.mod_depth      = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
        c.lfo_phase_step = 31'($urandom);
        return c;
    endfunction

    // Output side: random stall bursts, one long hold on request, and the
    // check of every accepted beat against the oldest expectation.
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_pair want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            beats_out++;
            if (expected_beats.size() == 0) begin
                $error("output beat with no expectation: %0d %0d",
                       out_if.out_left, out_if.out_right);
                fails++;
            end else begin
                want = expected_beats.pop_front();
                if (out_if.out_left !== want.left) begin
                    $error("out_left expected %0d got %0d", want.left, out_if.out_left);
                    fails++;
                end
                if (out_if.out_right !== want.right) begin
                    $error("out_right expected %0d got %0d", want.right, out_if.out_right);
                    fails++;
                end
            end
        end
        if (long_hold_req) begin
            stall_left = 600;
            long_hold_req <= 1'b0;
        end
        if (stall_left > 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 17);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Watchdog; the first stretch covers the memory clearing pass after reset.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    t_row directed[12];

    initial begin
        t_row row;
        t_cfg c;
        // After reset the lines are silent and wet is one half, so each
        // output is simply half the input, rounded toward minus infinity.
        directed[0]  = '{24'sh7FFFFF, 24'sh800000, 1, 24'sd4194303, -24'sd4194304};
        directed[1]  = '{24'sh800000, 24'sh7FFFFF, 1, -24'sd4194304, 24'sd4194303};
        directed[2]  = '{24'sd0, 24'sd0, 1, 24'sd0, 24'sd0};
        directed[3]  = '{-24'sd1, 24'sd1, 1, -24'sd1, 24'sd0};
        directed[4]  = '{24'sh555555, 24'shAAAAAA, 0, '0, '0};
        directed[5]  = '{24'shAAAAAA, 24'sh555555, 0, '0, '0};
        directed[6]  = '{24'sd2, -24'sd3, 1, 24'sd1, -24'sd2};
        directed[7]  = '{24'sh7FFFFF, 24'sh7FFFFF, 0, '0, '0};
        directed[8]  = '{24'sh800000, 24'sh800000, 0, '0, '0};
        directed[9]  = '{24'sh123456, -24'sh123456, 0, '0, '0};
        directed[10] = '{24'sh7FFFFF, -24'sd1, 0, '0, '0};
        directed[11] = '{24'sh000100, 24'shFFFF00, 0, '0, '0};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) begin
            send_beat(directed[k]);
        end
        drain();

        // Zero delay acts as one, the unknown filter mode passes the tap,
        // and feedback at the register limit saturates the line writes.
        c = CFG_RESET;
        c.delay_samples = 17'd0;
        c.filter_mode   = 2'd3;
        c.feedback_gain = 15'h7FFF;
        write_all(c);
        for (int k = 0; k < 5; k++) begin
            row = '{24'sh7FFFFF, 24'sh800000, 0, '0, '0};
            send_beat(row);
        end
        drain();

        // Wet mix above one drives the dry coefficient negative; high-pass
        // with crossed feedback and an LFO sweep.
        c.delay_samples  = 17'd3;
        c.wet_mix        = 16'hFFFF;
        c.ping_pong      = 1'b1;
        c.filter_mode    = FILT_HP;
        c.mod_depth      = 16'd32768;
        c.lfo_phase_step = 31'h7FFFFFFF;
        write_all(c);
        for (int k = 0; k < 5; k++) begin
            row = '{pick_sample(), pick_sample(), 0, '0, '0};
            send_beat(row);
        end
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0) begin
                c = '{17'h1FFFF, 15'h7FFF, 16'hFFFF, 1'b1, 2'd3, 16'hFFFF, 16'hFFFF,
                      31'h7FFFFFFF};
            end else if (ph == 1) begin
                c = '{17'd0, 15'd0, 16'd0, 1'b0, FILT_NONE, 16'd0, 16'd0, 31'd0};
            end else begin
                c = pick_setting();
            end
            write_all(c);
            idling_on = (ph < PHASES - 2);
            for (int k = 0; k < PER_PHASE; k++) begin
                if (ph == 4 && k == 20) begin
                    // Long output hold while beats keep coming, so the
                    // block backs up and stalls its input.
                    long_hold_req <= 1'b1;
                end
                if (ph == 6 && k == 45) begin
                    drain();
                end
                row = '{pick_sample(), pick_sample(), 0, '0, '0};
                send_beat(row);
            end
            drain();
        end

        $display("Covered %0d input beats and %0d output beats over %0d register settings,",
                 beats_in, beats_out, PHASES + 3);
        $display("with directed extremes, tone filter modes, ping-pong and LFO sweeps.");
        if (fails == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ stereo_feedback_delay_line.f @@
rtl/sfdl_pkg.sv
rtl/sfdl_in_if.sv
rtl/sfdl_out_if.sv
rtl/sfdl_lfo.sv
rtl/sfdl_chan.sv
rtl/stereo_feedback_delay_line.sv
rtl/sfdl_checker.sv
tb/testbench.sv
